>>> rtl/core/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

  // Coordinate format
  localparam int CW   = 32;          // coordinate width
  localparam int DW   = CW + 1;      // difference width
  localparam int PW   = 2 * DW;      // cross-product term width
  localparam int NW   = PW + 1;      // den / n1 / n2 width (signed)
  localparam int UW   = NW - 1;      // magnitude width after sign normalize
  localparam int HIW  = UW - DW;     // upper slice of n1 for the split multiply
  localparam int MAGW = CW + UW;     // |dir| * n1 width
  localparam int QB   = CW + 2;      // quotient bits kept before saturation
  localparam int SW   = QB + 3;      // origin +/- quotient width
  localparam int DIV_LAT = QB + 3;   // divider latency in cycles

  typedef struct packed {
    logic signed [CW-1:0] ray_origin_x;
    logic signed [CW-1:0] ray_origin_y;
    logic signed [CW-1:0] ray_dir_x;
    logic signed [CW-1:0] ray_dir_y;
    logic signed [CW-1:0] seg_start_x;
    logic signed [CW-1:0] seg_start_y;
    logic signed [CW-1:0] seg_end_x;
    logic signed [CW-1:0] seg_end_y;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/rsi_axis_div.sv
`default_nettype none
// origin + round(+/- mag / den), saturated; pipelined restoring divide.
module rsi_axis_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [rsi_pkg::MAGW-1:0]    mag,
  input  wire logic [rsi_pkg::UW-1:0]      den,
  input  wire logic                        neg,
  input  wire logic signed [rsi_pkg::CW-1:0] org,
  output logic signed [rsi_pkg::CW-1:0]    coord
);
  import rsi_pkg::*;

  localparam logic signed [SW-1:0] HI_LIM = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO_LIM = -HI_LIM - SW'(1);

  logic [UW-1:0]        rem_r [QB+1];
  logic [QB-1:0]        low_r [QB+1];
  logic [QB-1:0]        quo_r [QB+1];
  logic [UW-1:0]        den_r [QB+1];
  logic                 neg_r [QB+1];
  logic                 ovf_r [QB+1];
  logic signed [CW-1:0] org_r [QB+1];

  logic [QB:0]          qr_r;
  logic                 rneg_r, rovf_r;
  logic signed [CW-1:0] rorg_r;
  logic signed [CW-1:0] coord_r;
  logic signed [SW-1:0] sum;

  // entry: saturation check and remainder seed
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= UW'(mag[MAGW-1:QB]);
      ovf_r[0] <= UW'(mag[MAGW-1:QB]) >= den;
      low_r[0] <= mag[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      neg_r[0] <= neg;
      org_r[0] <= org;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [UW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_r[k-1], low_r[k-1][QB-1]};
      ge    = trial >= {1'b0, den_r[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? UW'(trial - {1'b0, den_r[k-1]}) : trial[UW-1:0];
        low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        org_r[k] <= org_r[k-1];
      end
    end
  end

  // round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      qr_r   <= {1'b0, quo_r[QB]} +
                (QB+1)'({rem_r[QB], 1'b0} >= {1'b0, den_r[QB]});
      rneg_r <= neg_r[QB];
      rovf_r <= ovf_r[QB];
      rorg_r <= org_r[QB];
    end
  end

  always_comb begin
    if (rneg_r) sum = SW'(rorg_r) - $signed({2'b00, qr_r});
    else        sum = SW'(rorg_r) + $signed({2'b00, qr_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (rovf_r) coord_r <= rneg_r ? LO_LIM[CW-1:0] : HI_LIM[CW-1:0];
      else if (sum > HI_LIM) coord_r <= HI_LIM[CW-1:0];
      else if (sum < LO_LIM) coord_r <= LO_LIM[CW-1:0];
      else coord_r <= sum[CW-1:0];
    end
  end

  assign coord = coord_r;

endmodule
`default_nettype wire

>>> rtl/core/ray_segment_intersection_top.sv
// Pipeline: 6 front stages, 37-stage divide/round/saturate per axis and
//   1 output register; the first front stage loads at the transfer edge.
// Throughput: one ray/segment pair per cycle; a stalled output freezes the
//   whole pipeline, nothing is lost or repeated.
// Reset: synchronous active-low rst_n clears all valid bits; data regs keep.
`default_nettype none
module ray_segment_intersection_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rsi_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsi_pkg::out_item_t      out_data
);
  import rsi_pkg::*;

  // Global advance: whole pipe moves unless a held result is being stalled.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences v2 = end - start, w = start - origin
  logic              s1_valid_r;
  logic signed [DW-1:0] v2x_r, v2y_r, wx_r, wy_r;
  logic signed [CW-1:0] s1_dx_r, s1_dy_r, s1_ox_r, s1_oy_r;

  // stage 2: the six cross-product terms
  logic              s2_valid_r;
  logic signed [PW-1:0] dxv2y_r, dyv2x_r, wxv2y_r, wyv2x_r, wxdy_r, wydx_r;
  logic signed [CW-1:0] s2_dx_r, s2_dy_r, s2_ox_r, s2_oy_r;

  // stage 3: den, n1, n2
  logic              s3_valid_r;
  logic signed [NW-1:0] den_r, n1_r, n2_r;
  logic signed [CW-1:0] s3_dx_r, s3_dy_r, s3_ox_r, s3_oy_r;

  // stage 4: sign-normalized, hit decision, |dir|
  logic              s4_valid_r, s4_hit_r;
  logic [UW-1:0]     s4_den_r, s4_n1_r;
  logic [CW-1:0]     s4_mx_r, s4_my_r;
  logic              s4_nx_r, s4_ny_r;
  logic signed [CW-1:0] s4_ox_r, s4_oy_r;

  // stage 5: split multiply |dir| * n1
  logic              s5_valid_r, s5_hit_r;
  logic [CW+DW-1:0]  plx_r, ply_r;
  logic [CW+HIW-1:0] phx_r, phy_r;
  logic [UW-1:0]     s5_den_r;
  logic              s5_nx_r, s5_ny_r;
  logic signed [CW-1:0] s5_ox_r, s5_oy_r;

  // stage 6: partial-product sum
  logic              s6_valid_r, s6_hit_r;
  logic [MAGW-1:0]   magx_r, magy_r;
  logic [UW-1:0]     s6_den_r;
  logic              s6_nx_r, s6_ny_r;
  logic signed [CW-1:0] s6_ox_r, s6_oy_r;

  // valid/hit alongside the divider
  logic              dv_valid_r [DIV_LAT];
  logic              dv_hit_r   [DIV_LAT];
  logic signed [CW-1:0] coord_x, coord_y;

  logic              out_valid_r;
  out_item_t         out_data_r;

  // normalize signs so den >= 0
  logic signed [NW-1:0] den_n, n1_n, n2_n;
  logic                 hit_n;
  always_comb begin
    if (den_r < 0) begin
      den_n = -den_r;
      n1_n  = -n1_r;
      n2_n  = -n2_r;
    end else begin
      den_n = den_r;
      n1_n  = n1_r;
      n2_n  = n2_r;
    end
    hit_n = (den_r != '0) && (n1_n >= 0) && (n2_n >= 0) && (n2_n <= den_n);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) dv_valid_r[i] <= 1'b0;
    end else if (en) begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      s5_valid_r    <= s4_valid_r;
      s6_valid_r    <= s5_valid_r;
      dv_valid_r[0] <= s6_valid_r;
      for (int i = 1; i < DIV_LAT; i++) dv_valid_r[i] <= dv_valid_r[i-1];
      out_valid_r   <= dv_valid_r[DIV_LAT-1];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      v2x_r   <= DW'(in_data.seg_end_x) - DW'(in_data.seg_start_x);
      v2y_r   <= DW'(in_data.seg_end_y) - DW'(in_data.seg_start_y);
      wx_r    <= DW'(in_data.seg_start_x) - DW'(in_data.ray_origin_x);
      wy_r    <= DW'(in_data.seg_start_y) - DW'(in_data.ray_origin_y);
      s1_dx_r <= in_data.ray_dir_x;
      s1_dy_r <= in_data.ray_dir_y;
      s1_ox_r <= in_data.ray_origin_x;
      s1_oy_r <= in_data.ray_origin_y;

      dxv2y_r <= PW'(s1_dx_r) * PW'(v2y_r);
      dyv2x_r <= PW'(s1_dy_r) * PW'(v2x_r);
      wxv2y_r <= PW'(wx_r) * PW'(v2y_r);
      wyv2x_r <= PW'(wy_r) * PW'(v2x_r);
      wxdy_r  <= PW'(wx_r) * PW'(s1_dy_r);
      wydx_r  <= PW'(wy_r) * PW'(s1_dx_r);
      s2_dx_r <= s1_dx_r;
      s2_dy_r <= s1_dy_r;
      s2_ox_r <= s1_ox_r;
      s2_oy_r <= s1_oy_r;

      den_r   <= NW'(dxv2y_r) - NW'(dyv2x_r);
      n1_r    <= NW'(wxv2y_r) - NW'(wyv2x_r);
      n2_r    <= NW'(wxdy_r) - NW'(wydx_r);
      s3_dx_r <= s2_dx_r;
      s3_dy_r <= s2_dy_r;
      s3_ox_r <= s2_ox_r;
      s3_oy_r <= s2_oy_r;

      s4_hit_r <= hit_n;
      s4_den_r <= den_n[UW-1:0];
      s4_n1_r  <= n1_n[UW-1:0];
      s4_nx_r  <= s3_dx_r[CW-1];
      s4_ny_r  <= s3_dy_r[CW-1];
      s4_mx_r  <= s3_dx_r[CW-1] ? CW'(~s3_dx_r + 1'b1) : s3_dx_r;
      s4_my_r  <= s3_dy_r[CW-1] ? CW'(~s3_dy_r + 1'b1) : s3_dy_r;
      s4_ox_r  <= s3_ox_r;
      s4_oy_r  <= s3_oy_r;

      plx_r    <= (CW+DW)'(s4_mx_r) * (CW+DW)'(s4_n1_r[DW-1:0]);
      ply_r    <= (CW+DW)'(s4_my_r) * (CW+DW)'(s4_n1_r[DW-1:0]);
      phx_r    <= (CW+HIW)'(s4_mx_r) * (CW+HIW)'(s4_n1_r[UW-1:DW]);
      phy_r    <= (CW+HIW)'(s4_my_r) * (CW+HIW)'(s4_n1_r[UW-1:DW]);
      s5_hit_r <= s4_hit_r;
      s5_den_r <= s4_den_r;
      s5_nx_r  <= s4_nx_r;
      s5_ny_r  <= s4_ny_r;
      s5_ox_r  <= s4_ox_r;
      s5_oy_r  <= s4_oy_r;

      magx_r   <= MAGW'(plx_r) + (MAGW'(phx_r) << DW);
      magy_r   <= MAGW'(ply_r) + (MAGW'(phy_r) << DW);
      s6_hit_r <= s5_hit_r;
      s6_den_r <= s5_den_r;
      s6_nx_r  <= s5_nx_r;
      s6_ny_r  <= s5_ny_r;
      s6_ox_r  <= s5_ox_r;
      s6_oy_r  <= s5_oy_r;

      dv_hit_r[0] <= s6_hit_r;
      for (int i = 1; i < DIV_LAT; i++) dv_hit_r[i] <= dv_hit_r[i-1];

      // no hit forces a zero point
      out_data_r.hit   <= dv_hit_r[DIV_LAT-1];
      out_data_r.hit_x <= dv_hit_r[DIV_LAT-1] ? coord_x : '0;
      out_data_r.hit_y <= dv_hit_r[DIV_LAT-1] ? coord_y : '0;
    end
  end

  rsi_axis_div u_div_x (
    .clk   (clk),
    .en    (en),
    .mag   (magx_r),
    .den   (s6_den_r),
    .neg   (s6_nx_r),
    .org   (s6_ox_r),
    .coord (coord_x)
  );

  rsi_axis_div u_div_y (
    .clk   (clk),
    .en    (en),
    .mag   (magy_r),
    .den   (s6_den_r),
    .neg   (s6_ny_r),
    .org   (s6_oy_r),
    .coord (coord_y)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_x == '0 && out_data.hit_y == '0)
    else $error("miss with nonzero point");
  a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r && s4_hit_r |-> s4_den_r != '0)
    else $error("hit with zero denominator");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && s1_valid_r |=> s2_valid_r)
    else $error("item dropped between stages");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

>>> verif/ray_segment_intersection_checker.sv
`timescale 1ns / 1ps
module ray_segment_intersection_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire rsi_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire rsi_pkg::out_item_t out_data,
  output int                      fail_count,
  output int                      pending
);
  import rsi_pkg::*;

  typedef logic signed [159:0] wide_t;

  out_item_t hits_due[$];

  function automatic logic signed [CW-1:0] hit_coord(wide_t o, wide_t d, wide_t n1, wide_t den);
    wide_t p, mag, q, s, hi, lo;
    p   = d * n1;
    mag = (p < 0) ? -p : p;
    q   = (2 * mag + den) / (2 * den);
    s   = (p < 0) ? o - q : o + q;
    hi  = 32'sh7fffffff;
    lo  = -wide_t'(32'sh7fffffff) - 1;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[CW-1:0];
  endfunction

  // Exact crossing test: den = dir x v2, n1 = w x v2, n2 = w x dir
  function automatic out_item_t cross_ray(in_item_t a);
    wide_t ox, oy, dx, dy, sx, sy, v2x, v2y, wx, wy, den, n1, n2;
    out_item_t r;
    ox  = $signed(a.ray_origin_x);
    oy  = $signed(a.ray_origin_y);
    dx  = $signed(a.ray_dir_x);
    dy  = $signed(a.ray_dir_y);
    sx  = $signed(a.seg_start_x);
    sy  = $signed(a.seg_start_y);
    v2x = wide_t'($signed(a.seg_end_x)) - sx;
    v2y = wide_t'($signed(a.seg_end_y)) - sy;
    wx  = sx - ox;
    wy  = sy - oy;
    den = dx * v2y - dy * v2x;
    n1  = wx * v2y - wy * v2x;
    n2  = wx * dy - wy * dx;
    r = '0;
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        n1  = -n1;
        n2  = -n2;
      end
      r.hit = (n1 >= 0) && (n2 >= 0) && (n2 <= den);
    end
    if (r.hit) begin
      r.hit_x = hit_coord(ox, dx, n1, den);
      r.hit_y = hit_coord(oy, dy, n1, den);
    end
    return r;
  endfunction

  assign pending = hits_due.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n) begin
      if (in_valid && !in_stall) hits_due.push_back(cross_ray(in_data));
      if (out_valid && !out_stall) begin
        if (hits_due.size() == 0) begin
          $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time,
                   out_data.hit, out_data.hit_x, out_data.hit_y);
          fail_count = fail_count + 1;
        end else begin
          exp_item = hits_due.pop_front();
          if (out_data.hit !== exp_item.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_item.hit, out_data.hit);
            fail_count = fail_count + 1;
          end
          if (out_data.hit_x !== exp_item.hit_x) begin
            $display("%0t: hit_x expected %0d actual %0d", $time,
                     exp_item.hit_x, out_data.hit_x);
            fail_count = fail_count + 1;
          end
          if (out_data.hit_y !== exp_item.hit_y) begin
            $display("%0t: hit_y expected %0d actual %0d", $time,
                     exp_item.hit_y, out_data.hit_y);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/ray_segment_intersection_top_test.sv
`timescale 1ns / 1ps
module ray_segment_intersection_top_test;
  import rsi_pkg::*;

  localparam int LATENCY   = 43;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 830;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle = 0;
  bit        hold_req = 1'b0;   // receiver: one long hold-off when set
  bit        burst = 1'b0;      // no idling on either side while set

  ray_segment_intersection_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ray_segment_intersection_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: limit is many times the slowest legal run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYC) begin
      $display("ray_segment_intersection_top_test failed");
      $finish;
    end
  end

  function automatic in_item_t pair(int ox, int oy, int dx, int dy,
                                    int sx, int sy, int ex, int ey);
    in_item_t r;
    r.ray_origin_x = ox; r.ray_origin_y = oy;
    r.ray_dir_x    = dx; r.ray_dir_y    = dy;
    r.seg_start_x  = sx; r.seg_start_y  = sy;
    r.seg_end_x    = ex; r.seg_end_y    = ey;
    return r;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000;
  endfunction

  // Segment with a point at k/8 along it; the ray is aimed at, away from,
  // or starts on that point.
  function automatic in_item_t aimed_pair();
    int sx, sy, ex, ey, px, py, ox, oy, k;
    sx = small_coord();
    sy = small_coord();
    ex = sx + 8 * (small_coord() >>> 4);
    ey = sy + 8 * (small_coord() >>> 4);
    k  = $urandom_range(0, 8);
    px = sx + ((ex - sx) / 8) * k;
    py = sy + ((ey - sy) / 8) * k;
    ox = small_coord();
    oy = small_coord();
    case ($urandom_range(0, 5))
      0:       return pair(ox, oy, ox - px, oy - py, sx, sy, ex, ey);  // points away
      1:       return pair(px, py, small_coord(), small_coord(), sx, sy, ex, ey);
      2:       return pair(ox, oy, (px - ox) >>> 3, (py - oy) >>> 3, sx, sy, ex, ey);
      default: return pair(ox, oy, px - ox, py - oy, sx, sy, ex, ey);
    endcase
  endfunction

  function automatic in_item_t any_pair();
    in_item_t r;
    int dx, dy, m;
    r = {$urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0, 1: begin
        // parallel: direction is a multiple of the segment vector
        dx = small_coord() >>> 6;
        dy = small_coord() >>> 6;
        m  = $urandom_range(1, 5);
        r = pair(small_coord(), small_coord(), dx * m, dy * m, r.seg_start_x >>> 2,
                 r.seg_start_y >>> 2, (r.seg_start_x >>> 2) + dx, (r.seg_start_y >>> 2) + dy);
      end
      2, 3, 4: ;
      default: r = aimed_pair();
    endcase
    return r;
  endfunction

  // Offer one item after a random gap; return after the transfer
  task automatic send(in_item_t item);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Receiver: random stall per transfer, plus one long hold on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      n = burst ? 0 : $urandom_range(0, 17);
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
      if (n != 0) @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, degenerate cases, endpoints, origin on segment
    send(pair(0, 0, 0, 0, 0, 0, 0, 0));
    send(pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send(pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send(pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send(pair(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send(pair(0, 0, 32'h10000, 0, 32'h50000, -32'h10000, 32'h50000, 32'h10000));
    send(pair(0, 0, 32'h10000, 0, 32'h50000, 0, 32'h50000, 32'h10000));   // start end
    send(pair(0, 0, 32'h10000, 0, 32'h50000, -32'h10000, 32'h50000, 0));  // far end
    send(pair(0, 0, 32'h10000, 0, 32'h50000, 1, 32'h50000, 32'h10000));   // just past
    send(pair(0, 0, -32'h10000, 0, 32'h50000, -32'h10000, 32'h50000, 32'h10000));
    send(pair(32'h50000, 0, 32'h3, 32'h7, 32'h50000, -32'h10000, 32'h50000, 32'h10000));
    send(pair(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h20000, 32'h30000)); // parallel
    send(pair(0, 0, 0, 0, 32'h50000, -32'h10000, 32'h50000, 32'h10000));  // zero dir
    send(pair(0, 0, 32'h10000, 0, 32'h50000, 32'h10000, 32'h50000, 32'h10000));
    send(pair(32'h7fff0000, 32'h7fff0000, -1, -3, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000));
    send(pair(1, 1, 32'h7fffffff, 1, 32'h7ffffffe, 32'h80000000, 32'h7ffffffe, 32'h7fffffff));
    send(pair(0, 0, 3, 1, 7, 0, 7, 5));   // rounding of a non-integer point
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == 200) begin
        // stall the output long enough for the pipeline to back up
        burst = 1'b1;
        hold_req = 1'b1;
      end
      if (i == 500) drain();
      send(any_pair());
    end
    drain();

    if (fail_count == 0) begin
      $display("ray_segment_intersection_top_test passed");
    end else begin
      $display("ray_segment_intersection_top_test failed");
    end
    $finish;
  end

endmodule
